FILE: rtl/caft_pkg.sv
// Shared types, constants and helpers for the CAN acceptance filter table.
package caft_pkg;

    localparam int HIT_W = 8;
    localparam int SLOT_W = 3;
    localparam int ID_W = 32;
    localparam int TAG_W = 8;

    localparam logic [ID_W-1:0] EFF_FLAG = 32'h8000_0000;
    localparam logic [ID_W-1:0] EFF_KEEP = 32'h9FFF_FFFF;
    localparam logic [ID_W-1:0] SFF_KEEP = 32'h0000_07FF;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_MATCH   = 2'd2
    } t_status;

    typedef enum logic {
        OP_REGISTER = 1'b0,
        OP_MATCH    = 1'b1
    } t_opcode;

    // Request travelling down the row of cells.
    typedef struct packed {
        logic               valid;
        t_opcode            opcode;
        logic [ID_W-1:0]    frame_id;
        logic [ID_W-1:0]    mask;
        logic [ID_W-1:0]    value;
        logic               placed;
        logic [SLOT_W-1:0]  slot;
        logic [HIT_W-1:0]   hits;
    } t_token;

    function automatic logic [ID_W-1:0] clean_mask(input logic [ID_W-1:0] m);
        logic [ID_W-1:0] res;
        if ((m & EFF_FLAG) != '0) begin
            res = m & EFF_KEEP;
        end else begin
            res = m & SFF_KEEP;
        end
        return res;
    endfunction

endpackage

FILE: rtl/caft_cell.sv
// One filter entry cell: stores an entry and processes the request passing through.
module caft_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  caft_pkg::t_token i_tok,
    output caft_pkg::t_token o_tok,
    output logic            o_used
);
    import caft_pkg::*;

    localparam logic [SLOT_W-1:0] SLOT_NUM = SLOT_W'(CELL_IDX);
    localparam bit HAS_HIT = (CELL_IDX < HIT_W);
    localparam logic [$clog2(HIT_W)-1:0] HIT_POS = $clog2(HIT_W)'(CELL_IDX % HIT_W);

    logic            r_used;
    logic [ID_W-1:0] r_mask;
    logic [ID_W-1:0] r_filter;
    t_token          r_tok;
    t_token          n_tok;
    logic            w_claim;
    logic            w_hit;

    always_comb begin
        w_claim = i_tok.valid && (i_tok.opcode == OP_REGISTER) && !i_tok.placed && !r_used;
        w_hit   = i_tok.valid && (i_tok.opcode == OP_MATCH) && r_used &&
                  (((i_tok.frame_id ^ r_filter) & r_mask) == '0);
        n_tok = i_tok;
        if (w_claim) begin
            n_tok.placed = 1'b1;
            n_tok.slot   = SLOT_NUM;
        end
        if (HAS_HIT && w_hit) begin
            n_tok.hits[HIT_POS] = 1'b1;
        end
    end

    // Reset clears only the valid and used bits; the payload holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_advance) begin
            r_tok <= n_tok;
            if (w_claim) begin
                r_used   <= 1'b1;
                r_mask   <= i_tok.mask;
                r_filter <= i_tok.value;
            end
        end
    end

    assign o_tok  = r_tok;
    assign o_used = r_used;

endmodule

FILE: rtl/can_acceptance_filter_table.sv
// Top level of the CAN acceptance filter table: a row of entry cells.
// Each accepted request is registered once in every cell on its way to the result.
// Throughput: one request per cycle; the row stalls as a whole while a result waits.
// Each cell owns one entry; a request visits cell 0 first and reaches the output after the last.
// Reset (synchronous, active low) frees every entry and drops requests in flight.
// Entry payloads are not cleared; a free entry is never read.
module can_acceptance_filter_table #(
    parameter int ENTRIES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // frame_id[31:0], filter_mask[63:32], filter_value[95:64], handler_tag[103:96]
    input  logic [103:0] i_s_axis_tdata,
    // opcode[0]
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // slot[2:0], hit_vector[10:3], zero[15:11]
    output logic [15:0]  o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]   o_m_axis_tuser
);
    import caft_pkg::*;

    t_token               w_tok [ENTRIES+1];
    logic [ENTRIES-1:0]   w_used;
    logic                 w_advance;
    t_token               w_last;
    t_status              w_status;

    // Move the whole row whenever the result slot is empty or being taken.
    assign w_last    = w_tok[ENTRIES];
    assign w_advance = !w_last.valid || i_m_axis_tready;
    assign o_s_axis_tready = w_advance;

    // Build the request; clean the mask once on entry. The handler tag has no
    // observable effect on any result, so it is not kept in the row.
    always_comb begin
        w_tok[0].valid    = i_s_axis_tvalid;
        w_tok[0].opcode   = t_opcode'(i_s_axis_tuser[0]);
        w_tok[0].frame_id = i_s_axis_tdata[31:0];
        w_tok[0].mask     = clean_mask(i_s_axis_tdata[63:32]);
        w_tok[0].value    = i_s_axis_tdata[95:64];
        w_tok[0].placed   = 1'b0;
        w_tok[0].slot     = '0;
        w_tok[0].hits     = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        caft_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1]),
            .o_used    (w_used[g])
        );
    end

    // Status follows from the opcode and whether any cell claimed the request.
    always_comb begin
        if (w_last.opcode == OP_MATCH) begin
            w_status = ST_MATCH;
        end else if (w_last.placed) begin
            w_status = ST_STORED;
        end else begin
            w_status = ST_NO_ROOM;
        end
    end

    assign o_m_axis_tvalid = w_last.valid;
    assign o_m_axis_tuser  = w_status;
    assign o_m_axis_tdata  = {5'b0, w_last.hits, w_last.slot};

    // A refused entry implies every cell was already taken.
    a_no_room_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_NO_ROOM)) |-> (&w_used))
        else $error("no-room result while a cell is free");

    // Register results never carry hits; match results never carry a slot.
    a_store_no_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_MATCH)) |-> (o_m_axis_tdata[10:3] == '0))
        else $error("hits on a register result");

    a_match_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_MATCH)) |-> (o_m_axis_tdata[2:0] == '0))
        else $error("slot set on a match result");

    // Used cells only grow outside reset, one at a time.
    a_used_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_used & ~$past(w_used)) != '0) |->
            ($countones(w_used) == $countones($past(w_used)) + 1))
        else $error("more than one cell claimed per cycle");

    // An accepted request sits in the first cell in the next cycle.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_axis_tready && i_s_axis_tvalid) |=> w_tok[1].valid)
        else $error("accepted request lost at first cell");

endmodule

FILE: test/can_acceptance_filter_table_tb.sv
`timescale 1ns / 1ps
// Testbench for the CAN acceptance filter table: directed and random requests against a local table.
module can_acceptance_filter_table_tb;
    import caft_pkg::*;

    localparam int N_ENTRIES    = 8;
    localparam int N_RANDOM     = 680;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4 * N_ENTRIES;

    // One request as the sender sees it, before packing onto the stream.
    typedef struct {
        t_opcode           op;
        logic [ID_W-1:0]   frame_id;
        logic [ID_W-1:0]   mask;
        logic [ID_W-1:0]   value;
        logic [TAG_W-1:0]  tag;
    } t_request;

    // One result as the block should return it.
    typedef struct {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [HIT_W-1:0]   hits;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic [1:0]   m_tuser;

    // Local copy of the filter table, updated as each request is accepted.
    bit              tbl_used  [N_ENTRIES];
    logic [ID_W-1:0] tbl_mask  [N_ENTRIES];
    logic [ID_W-1:0] tbl_value [N_ENTRIES];
    logic [TAG_W-1:0] tbl_tag  [N_ENTRIES];

    // Entries as the stimulus builder expects them to land; used only to aim frame ids.
    logic [ID_W-1:0] aim_mask  [N_ENTRIES];
    logic [ID_W-1:0] aim_value [N_ENTRIES];
    int              aim_count = 0;

    t_request pending_requests[$];
    t_result  awaited_results[$];
    t_request taken_request;
    t_request next_request;
    t_result  due_result;

    int requests_total    = 0;
    int requests_accepted = 0;
    int errors            = 0;
    int cycle_count       = 0;

    can_acceptance_filter_table #(
        .ENTRIES(N_ENTRIES)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Keep only the flag and 29 id bits of an extended mask, or the 11 id bits of a standard one.
    function automatic logic [ID_W-1:0] clean_id_mask(input logic [ID_W-1:0] m);
        if (m[31]) begin
            return {1'b1, 2'b00, m[28:0]};
        end
        return {21'b0, m[10:0]};
    endfunction

    // Apply one request to the local table and return the result it should produce.
    function automatic t_result filter_table_apply(input t_request rq);
        t_result r;
        bit      placed;
        r.status = ST_MATCH;
        r.slot   = '0;
        r.hits   = '0;
        placed   = 1'b0;
        if (rq.op == OP_REGISTER) begin
            r.status = ST_NO_ROOM;
            for (int k = 0; k < N_ENTRIES; k++) begin
                if (!placed && !tbl_used[k]) begin
                    placed       = 1'b1;
                    tbl_used[k]  = 1'b1;
                    tbl_mask[k]  = clean_id_mask(rq.mask);
                    tbl_value[k] = rq.value;
                    tbl_tag[k]   = rq.tag;
                    r.status     = ST_STORED;
                    r.slot       = k[SLOT_W-1:0];
                end
            end
        end else begin
            for (int k = 0; k < N_ENTRIES && k < HIT_W; k++) begin
                if (tbl_used[k] &&
                    ((rq.frame_id & tbl_mask[k]) == (tbl_value[k] & tbl_mask[k]))) begin
                    r.hits[k] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Idle percentage for one side: sender light and receiver heavy first, then swapped,
    // then no idling at all.
    function automatic int idle_pct(input bit for_sender);
        int phase;
        if (requests_total == 0) begin
            return 0;
        end
        phase = requests_accepted * 3 / requests_total;
        if (phase == 0) begin
            return for_sender ? 8 : 83;
        end
        if (phase == 1) begin
            return for_sender ? 83 : 8;
        end
        return 0;
    endfunction

    // Queue a request; track where a register request should land so later frame ids can aim at it.
    task automatic add_request(input t_opcode op, input logic [ID_W-1:0] frame_id,
                               input logic [ID_W-1:0] mask, input logic [ID_W-1:0] value,
                               input logic [TAG_W-1:0] tag);
        t_request rq;
        rq.op       = op;
        rq.frame_id = frame_id;
        rq.mask     = mask;
        rq.value    = value;
        rq.tag      = tag;
        if (op == OP_REGISTER && aim_count < N_ENTRIES) begin
            aim_mask[aim_count]  = mask;
            aim_value[aim_count] = value;
            aim_count++;
        end
        pending_requests.push_back(rq);
    endtask

    // Build a frame id that passes entry k's filter, with random bits where the mask ignores them.
    function automatic logic [ID_W-1:0] aimed_id(input int k);
        logic [ID_W-1:0] cm;
        cm = clean_id_mask(aim_mask[k]);
        return (aim_value[k] & cm) | ($urandom() & ~cm);
    endfunction

    // Driver: hold a request until it is taken, then predict its result and offer the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken_request.frame_id = s_tdata[31:0];
                taken_request.mask     = s_tdata[63:32];
                taken_request.value    = s_tdata[95:64];
                taken_request.tag      = s_tdata[103:96];
                taken_request.op       = t_opcode'(s_tuser[0]);
                awaited_results.push_back(filter_table_apply(taken_request));
                requests_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                    next_request = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_request.tag, next_request.value,
                                 next_request.mask, next_request.frame_id};
                    s_tuser  <= next_request.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result with the oldest prediction, then stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: status %0d slot %0d hits %02h",
                             $time, m_tuser, m_tdata[2:0], m_tdata[10:3]);
                    errors++;
                end else begin
                    due_result = awaited_results.pop_front();
                    if (m_tuser != due_result.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, due_result.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[2:0] != due_result.slot) begin
                        $display("%0t: slot mismatch: expected %0d, actual %0d",
                                 $time, due_result.slot, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[10:3] != due_result.hits) begin
                        $display("%0t: hit vector mismatch: expected %02h, actual %02h",
                                 $time, due_result.hits, m_tdata[10:3]);
                        errors++;
                    end
                    if (m_tdata[15:11] != '0) begin
                        $display("%0t: pad bits mismatch: expected %02h, actual %02h",
                                 $time, 5'h00, m_tdata[15:11]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // Watchdog: abort a run that stops making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int              pick;
        int              flip;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] m;

        // Match against an empty table: nothing may hit.
        add_request(OP_MATCH, 32'h0000_0000, $urandom(), $urandom(), 8'($urandom_range(255)));
        // Extended mask with every bit set: RTR and ERR bits drop out.
        add_request(OP_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h9234_5678, 8'hFF);
        // Standard mask: only the low 11 id bits survive.
        add_request(OP_REGISTER, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0123, 8'h00);
        // Empty mask: accept every frame.
        add_request(OP_REGISTER, $urandom(), 32'h0000_0000, 32'hFFFF_FFFF, 8'h5A);
        // Fill the rest with sparse random masks so aimed ids still hit several entries.
        for (int n = 0; n < N_ENTRIES - 3; n++) begin
            m     = $urandom() & $urandom();
            m[31] = 1'($urandom_range(1));
            add_request(OP_REGISTER, $urandom(), m, $urandom(), 8'($urandom_range(255)));
        end
        // Table full: both requests must be refused and change nothing.
        add_request(OP_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        add_request(OP_REGISTER, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00);
        // Extreme ids, flag bits ignored by the extended entry, upper bits ignored by the standard one.
        add_request(OP_MATCH, 32'h0000_0000, 32'h0, 32'h0, 8'h00);
        add_request(OP_MATCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        add_request(OP_MATCH, 32'hF234_5678, $urandom(), $urandom(), 8'($urandom_range(255)));
        add_request(OP_MATCH, 32'hFFFF_F923, $urandom(), $urandom(), 8'($urandom_range(255)));
        add_request(OP_MATCH, 32'h1234_5678, $urandom(), $urandom(), 8'($urandom_range(255)));
        for (int k = 3; k < N_ENTRIES; k++) begin
            add_request(OP_MATCH, aimed_id(k), $urandom(), $urandom(),
                        8'($urandom_range(255)));
        end

        // Random part: mostly aimed matches, some with one bit broken, plus noise.
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                add_request(OP_REGISTER, $urandom(), $urandom(), $urandom(),
                            8'($urandom_range(255)));
            end else if (pick < 25) begin
                add_request(OP_MATCH, $urandom(), $urandom(), $urandom(),
                            8'($urandom_range(255)));
            end else begin
                id = aimed_id($urandom_range(aim_count - 1));
                if ($urandom_range(3) == 0) begin
                    flip     = $urandom_range(ID_W - 1);
                    id[flip] = ~id[flip];
                end
                add_request(OP_MATCH, id, $urandom(), $urandom(), 8'($urandom_range(255)));
            end
        end
        requests_total = pending_requests.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and every result to come back, then drain.
        while (requests_accepted < requests_total || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
